[src/lit_pkg.sv]
// Shared types, constants and table functions for the log intensity transform.
// Depends on nothing; every other file of the block uses it.
package lit_pkg;

    localparam int PIXEL_BITS_DEF    = 8;
    localparam int LOG_FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam longint unsigned LN2_Q32 = 64'h0000_0000_B172_17F8;

    typedef enum logic
    {
        OP_SCAN      = 1'b0,
        OP_TRANSFORM = 1'b1
    } opcode_t;

    // Integer part must hold ln(2^pixel_bits) < pixel_bits.
    function automatic int ln_width(input int pixel_bits, input int frac_bits);
        return frac_bits + $clog2(pixel_bits + 1);
    endfunction

    // Shift-subtract unsigned division, for the table build only.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], num[i]};
            q = {q[62:0], 1'b0};
            if (r >= den)
            begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(ln(v) * 2^frac_bits) for v >= 1, from a Q32 atanh series plus k*ln2.
    // Evaluated at elaboration only, to fill the constant table.
    function automatic longint unsigned fixed_ln(input int unsigned v,
                                                 input int unsigned frac_bits);
        int unsigned     k;
        int unsigned     j;
        longint unsigned vv;
        longint unsigned p;
        longint unsigned z;
        longint unsigned z2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned ln;
        k  = 0;
        vv = longint'(v);
        while ((v >> (k + 1)) != 0)
        begin
            k++;
        end
        p    = 64'd1 << k;
        z    = div_u64((vv - p) << 32, vv + p);
        z2   = (z * z) >> 32;
        term = z;
        sum  = 0;
        for (j = 0; j < 40 && term != 0; j++)
        begin
            sum  = sum + div_u64(term, longint'(2 * j + 1));
            term = (term * z2) >> 32;
        end
        ln = longint'(k) * LN2_Q32 + 2 * sum;
        ln = (ln + (64'd1 << (31 - frac_bits))) >> (32 - frac_bits);
        return ln;
    endfunction

endpackage

[src/lit_ifs.sv]
// Valid/ready channel interfaces for the pixel input and result output.
// Depends on lit_pkg for default widths.
interface lit_in_if #(parameter int PIXEL_BITS = lit_pkg::PIXEL_BITS_DEF);
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  frame_start;

    modport source (output valid, opcode, pixel, frame_start, input ready);
    modport sink   (input valid, opcode, pixel, frame_start, output ready);
endinterface

interface lit_out_if #(parameter int PIXEL_BITS = lit_pkg::PIXEL_BITS_DEF);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] out_pixel;

    modport source (output valid, out_pixel, input ready);
    modport sink   (input valid, out_pixel, output ready);
endinterface

[src/log_intensity_transform.sv]
// Path: a scan updates the registered running maximum on acceptance; a transform
// passes the front stage, the queue, the divider states B_CHECK and B_DIV and the
// output register, and skips B_DIV when the maximum is zero or the quotient saturates.
// Throughput: scans one per cycle while in_stream.ready is high; the bit-serial divider
// takes a new transform only once idle, and yields one quotient bit per cycle.
// Reset (rst_n low, asynchronous) clears the running maximum, queue and divider.
module log_intensity_transform #(
    parameter int PIXEL_BITS    = lit_pkg::PIXEL_BITS_DEF,
    parameter int LOG_FRAC_BITS = lit_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lit_in_if.sink    in_stream,
    lit_out_if.source out_stream
);
    import lit_pkg::*;

    localparam int LN_W = ln_width(PIXEL_BITS, LOG_FRAC_BITS);

    logic              front_valid;
    logic              front_ready;
    logic [2*LN_W-1:0] front_data;
    logic              back_valid;
    logic              back_ready;
    logic [2*LN_W-1:0] back_data;

    lit_front #(
        .PIXEL_BITS    (PIXEL_BITS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job_data  (front_data)
    );

    lit_queue #(
        .WIDTH (2 * LN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_data)
    );

    lit_back #(
        .PIXEL_BITS    (PIXEL_BITS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (back_valid),
        .job_ready  (back_ready),
        .job_data   (back_data),
        .out_stream (out_stream)
    );

endmodule

[src/lit_front.sv]
// Front end: accepts transactions, tracks the running maximum on scans and
// looks up both log values for transforms. Depends on lit_pkg and lit_ifs.
module lit_front #(
    parameter int PIXEL_BITS    = lit_pkg::PIXEL_BITS_DEF,
    parameter int LOG_FRAC_BITS = lit_pkg::LOG_FRAC_BITS_DEF,
    localparam int LN_W         = lit_pkg::ln_width(PIXEL_BITS, LOG_FRAC_BITS)
) (
    input  logic              clk,
    input  logic              rst_n,
    lit_in_if.sink            in_stream,
    output logic              job_valid,
    input  logic              job_ready,
    output logic [2*LN_W-1:0] job_data
);
    import lit_pkg::*;

    localparam int LEVELS = 1 << PIXEL_BITS;

    logic [LN_W-1:0]       ln_rom [LEVELS];
    logic [PIXEL_BITS-1:0] max_level_reg;
    logic [PIXEL_BITS-1:0] max_level_next;
    logic [PIXEL_BITS-1:0] max_base;
    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    logic [LN_W-1:0]       ln_num_reg;
    logic [LN_W-1:0]       ln_num_next;
    logic [LN_W-1:0]       ln_den_reg;
    logic [LN_W-1:0]       ln_den_next;
    logic                  accept;
    logic                  transform;

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_ln_rom
        localparam logic [LN_W-1:0] LN_VAL =
            LN_W'(fixed_ln(g + 1, LOG_FRAC_BITS));
        assign ln_rom[g] = LN_VAL;
    end

    assign in_stream.ready = !stage_valid_reg || job_ready;
    assign accept          = in_stream.valid && in_stream.ready;
    assign transform       = opcode_t'(in_stream.opcode) == OP_TRANSFORM;

    always_comb
    begin
        max_base       = in_stream.frame_start ? '0 : max_level_reg;
        max_level_next = max_level_reg;
        if (accept && !transform)
        begin
            max_level_next = (in_stream.pixel > max_base) ? in_stream.pixel : max_base;
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        ln_num_next      = ln_num_reg;
        ln_den_next      = ln_den_reg;
        if (accept && transform)
        begin
            stage_valid_next = 1'b1;
            ln_num_next      = ln_rom[in_stream.pixel];
            ln_den_next      = ln_rom[max_level_reg];
        end
        else if (job_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg   <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            max_level_reg   <= max_level_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ln_num_reg <= ln_num_next;
        ln_den_reg <= ln_den_next;
    end

    assign job_valid = stage_valid_reg;
    assign job_data  = {ln_num_reg, ln_den_reg};

endmodule

[src/lit_queue.sv]
// Short register queue between the front end and the divider back end.
// Depends on lit_pkg for the default depth.
module lit_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lit_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import lit_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[src/lit_back.sv]
// Back end: saturating restoring divider, one quotient bit per cycle, and
// the output register. Depends on lit_pkg and lit_ifs.
module lit_back #(
    parameter int PIXEL_BITS    = lit_pkg::PIXEL_BITS_DEF,
    parameter int LOG_FRAC_BITS = lit_pkg::LOG_FRAC_BITS_DEF,
    localparam int LN_W         = lit_pkg::ln_width(PIXEL_BITS, LOG_FRAC_BITS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  logic [2*LN_W-1:0] job_data,
    lit_out_if.source         out_stream
);
    import lit_pkg::*;

    localparam int NUM_W  = LN_W + PIXEL_BITS;
    localparam int STEP_W = $clog2(PIXEL_BITS);

    typedef enum logic [1:0]
    {
        B_IDLE,
        B_CHECK,
        B_DIV,
        B_DONE
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [NUM_W-1:0]      rem_reg;
    logic [NUM_W-1:0]      rem_next;
    logic [LN_W-1:0]       den_reg;
    logic [LN_W-1:0]       den_next;
    logic [NUM_W-1:0]      dsh_reg;
    logic [NUM_W-1:0]      dsh_next;
    logic [PIXEL_BITS-1:0] quo_reg;
    logic [PIXEL_BITS-1:0] quo_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PIXEL_BITS-1:0] out_pixel_reg;
    logic [PIXEL_BITS-1:0] out_pixel_next;
    logic [LN_W-1:0]       ln_num;
    logic [LN_W-1:0]       ln_den;
    logic                  ge;
    logic                  out_free;

    assign ln_num    = job_data[2*LN_W-1:LN_W];
    assign ln_den    = job_data[LN_W-1:0];
    assign job_ready = state_reg == B_IDLE;
    assign ge        = rem_reg >= dsh_reg;
    assign out_free  = !out_valid_reg || out_stream.ready;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_pixel_next = out_pixel_reg;
        out_valid_next = out_stream.ready ? 1'b0 : out_valid_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    // Scale the numerator by full scale: x * (2^n - 1).
                    rem_next   = (NUM_W'(ln_num) << PIXEL_BITS) - NUM_W'(ln_num);
                    den_next   = ln_den;
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if (den_reg == '0)
                begin
                    quo_next   = '0;
                    state_next = B_DONE;
                end
                else if (rem_reg >= (NUM_W'(den_reg) << PIXEL_BITS))
                begin
                    quo_next   = '1;
                    state_next = B_DONE;
                end
                else
                begin
                    dsh_next   = NUM_W'(den_reg) << (PIXEL_BITS - 1);
                    quo_next   = '0;
                    step_next  = STEP_W'(PIXEL_BITS - 1);
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next  = {quo_reg[PIXEL_BITS-2:0], ge};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_pixel_next = quo_reg;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rem_reg       <= '0;
            den_reg       <= '0;
            dsh_reg       <= '0;
            quo_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_pixel_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            den_reg       <= den_next;
            dsh_reg       <= dsh_next;
            quo_reg       <= quo_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign out_stream.valid     = out_valid_reg;
    assign out_stream.out_pixel = out_pixel_reg;

endmodule

[src/lit_checker.sv]
// Port-level checks for the log intensity transform, bound to the top level.
// Depends on lit_pkg and the log_intensity_transform module.
module lit_checker #(
    parameter int PIXEL_BITS = lit_pkg::PIXEL_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  in_opcode,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [PIXEL_BITS-1:0] out_pixel
);
    import lit_pkg::*;

    // Front stage, queue, divider and output register.
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 3;

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       in_xact;
    logic       out_xact;

    assign in_xact  = in_valid && in_ready && (opcode_t'(in_opcode) == OP_TRANSFORM);
    assign out_xact = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_xact && !out_xact)
        begin
            pending_next = pending_reg + 8'd1;
        end
        else if (out_xact && !in_xact)
        begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_out_hold_pixel : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_pixel))
        else $error("result payload changed while stalled");

    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("result with no transform outstanding");

    a_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 8'(MAX_INFLIGHT))
        else $error("more transforms in flight than the block can hold");

endmodule

bind log_intensity_transform lit_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_lit_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .in_opcode (in_stream.opcode),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_pixel (out_stream.out_pixel)
);
